>>> hw/rtl/dhc_pkg.sv
// shared types and constants for the dereplication hash counter
// no dependencies
package dhc_pkg;

   localparam int TABLE_ENTRIES_DEF = 4096;
   localparam int FILL_NUM          = 95;
   localparam int FILL_DEN          = 100;
   localparam int HASH_W            = 64;
   localparam int LEN_W             = 32;
   localparam int ABUND_W           = 24;
   localparam int COUNT_W           = 32;
   localparam int SUM_W             = 40;
   localparam int CSR_IDX_W         = 3;
   localparam int CSR_DATA_W        = 32;

   typedef enum logic [2:0] {
      STATUS_SHORT,
      STATUS_LONG,
      STATUS_NEW,
      STATUS_ADDED,
      STATUS_FULL,
      STATUS_WRITE,
      STATUS_OUT_OF_BOUNDS,
      STATUS_ABSENT
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_LENGTH,
      CSR_MAX_LENGTH,
      CSR_BOTH_STRANDS,
      CSR_USE_INPUT_ABUNDANCE,
      CSR_MIN_UNIQUE_SIZE,
      CSR_MAX_UNIQUE_SIZE
   } csr_index_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_LENGTH,
      FSM_PROBE,
      FSM_COMMIT
   } fsm_state_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic start_plus;
      logic start_minus;
      logic probe_step;
      logic probe_finish;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic length_bad;
      logic probe_hit;
      logic probe_done;
      logic on_minus;
      logic both_strands;
      logic rsp_free;
   } dp_status_type;

endpackage

>>> hw/rtl/dhc_ctrl.sv
// controller state machine: clearing pass, item sequencing and probe walk
// depends on dhc_pkg
module dhc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  dhc_pkg::dp_status_type dp_status,
   output dhc_pkg::dp_cmd_type    dp_cmd
);
   import dhc_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         FSM_CLEAR: begin
            dp_cmd.clear_step = 1'b1;
            if (dp_status.clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.load_item = 1'b1;
               state_in         = FSM_LENGTH;
            end
         end
         FSM_LENGTH: begin
            if (dp_status.length_bad) begin
               state_in = FSM_COMMIT;
            end else begin
               dp_cmd.start_plus = 1'b1;
               state_in          = FSM_PROBE;
            end
         end
         FSM_PROBE: begin
            if (dp_status.probe_done) begin
               dp_cmd.probe_finish = 1'b1;
               if (!dp_status.probe_hit && dp_status.both_strands && !dp_status.on_minus) begin
                  dp_cmd.start_minus = 1'b1;
               end else begin
                  state_in = FSM_COMMIT;
               end
            end else begin
               dp_cmd.probe_step = 1'b1;
            end
         end
         FSM_COMMIT: begin
            if (dp_status.rsp_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_CLEAR;
         end
      endcase
   end

endmodule

>>> hw/rtl/dhc_datapath.sv
// datapath: config registers, item registers, hash table memory, totals and result register
// depends on dhc_pkg
module dhc_datapath #(
   parameter int TABLE_ENTRIES = dhc_pkg::TABLE_ENTRIES_DEF,
   localparam int IDX_W = $clog2(TABLE_ENTRIES),
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dhc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dhc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_opcode,
   input  logic [dhc_pkg::HASH_W-1:0]      req_plus_hash_high,
   input  logic [dhc_pkg::HASH_W-1:0]      req_plus_hash_low,
   input  logic [dhc_pkg::HASH_W-1:0]      req_minus_hash_high,
   input  logic [dhc_pkg::HASH_W-1:0]      req_minus_hash_low,
   input  logic [dhc_pkg::LEN_W-1:0]       req_seq_length,
   input  logic [dhc_pkg::ABUND_W-1:0]     req_abundance,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dhc_pkg::status_type             rsp_status,
   output logic [dhc_pkg::COUNT_W-1:0]     rsp_cluster_count,
   output logic [IDX_W-1:0]                rsp_slot_index,
   output logic [CNT_W-1:0]                rsp_cluster_total,
   output logic [dhc_pkg::COUNT_W-1:0]     rsp_largest_count,
   output logic [dhc_pkg::SUM_W-1:0]       rsp_abundance_sum,
   output logic [CNT_W-1:0]                rsp_written_total,
   input  dhc_pkg::dp_cmd_type             dp_cmd,
   output dhc_pkg::dp_status_type          dp_status
);
   import dhc_pkg::*;

   localparam int FILL_LIMIT = (FILL_NUM * TABLE_ENTRIES) / FILL_DEN;

   typedef struct packed {
      logic [2*HASH_W-1:0] hash;
      logic [COUNT_W-1:0]  count;
      logic                written;
   } entry_type;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_ff;
   entry_type wr_data;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;

   logic [LEN_W-1:0]   min_length_ff, max_length_ff;
   logic [COUNT_W-1:0] min_unique_ff, max_unique_ff;
   logic               both_strands_ff, use_abund_ff;

   logic                opcode_ff;
   logic [2*HASH_W-1:0] plus_hash_ff, minus_hash_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [ABUND_W-1:0]  abund_ff;

   logic [IDX_W-1:0]    addr_ff, addr_in, addr_next;
   logic [IDX_W-1:0]    steps_ff;
   logic                on_minus_ff;
   logic [2*HASH_W-1:0] probe_key;
   logic                probe_hit, probe_free, probe_last;

   logic                found_ff, pfree_ff;
   logic [IDX_W-1:0]    slot_ff;
   logic [COUNT_W-1:0]  hit_count_ff;
   logic                hit_written_ff;
   logic [2*HASH_W-1:0] hit_hash_ff;

   logic [CNT_W-1:0]   distinct_ff, distinct_in;
   logic [COUNT_W-1:0] max_count_ff, max_count_in;
   logic [SUM_W-1:0]   total_ff, total_in;
   logic [CNT_W-1:0]   selected_ff, selected_in;

   logic               rsp_valid_ff;
   status_type         status_in;
   logic [COUNT_W-1:0] count_in;
   logic [IDX_W-1:0]   slot_in;

   logic [ABUND_W-1:0] ab_eff;
   logic [COUNT_W:0]   cnt_sum;
   logic [COUNT_W-1:0] cnt_sat;
   logic [SUM_W:0]     tot_sum;
   logic               table_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff   <= LEN_W'(1);
         max_length_ff   <= '1;
         both_strands_ff <= 1'b0;
         use_abund_ff    <= 1'b0;
         min_unique_ff   <= COUNT_W'(1);
         max_unique_ff   <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_LENGTH:          min_length_ff   <= csr_data;
            CSR_MAX_LENGTH:          max_length_ff   <= csr_data;
            CSR_BOTH_STRANDS:        both_strands_ff <= csr_data[0];
            CSR_USE_INPUT_ABUNDANCE: use_abund_ff    <= csr_data[0];
            CSR_MIN_UNIQUE_SIZE:     min_unique_ff   <= csr_data;
            CSR_MAX_UNIQUE_SIZE:     max_unique_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load_item) begin
         opcode_ff     <= req_opcode;
         plus_hash_ff  <= {req_plus_hash_high, req_plus_hash_low};
         minus_hash_ff <= {req_minus_hash_high, req_minus_hash_low};
         len_ff        <= req_seq_length;
         abund_ff      <= req_abundance;
      end
   end

   // probe walk
   assign addr_next  = (addr_ff == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : addr_ff + 1'b1;
   assign probe_key  = on_minus_ff ? minus_hash_ff : plus_hash_ff;
   assign probe_free = (rd_ff.count == '0);
   assign probe_hit  = !probe_free && (rd_ff.hash == probe_key);
   assign probe_last = (steps_ff == IDX_W'(TABLE_ENTRIES - 1));

   always_comb begin
      addr_in = addr_ff;
      if (dp_cmd.start_plus) begin
         addr_in = plus_hash_ff[IDX_W-1:0];
      end else if (dp_cmd.start_minus) begin
         addr_in = minus_hash_ff[IDX_W-1:0];
      end else if (dp_cmd.probe_step || dp_cmd.clear_step) begin
         addr_in = addr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         steps_ff    <= '0;
         on_minus_ff <= 1'b0;
      end else begin
         addr_ff <= addr_in;
         if (dp_cmd.start_plus || dp_cmd.start_minus) begin
            steps_ff <= '0;
         end else if (dp_cmd.probe_step) begin
            steps_ff <= steps_ff + 1'b1;
         end
         if (dp_cmd.start_plus) begin
            on_minus_ff <= 1'b0;
         end else if (dp_cmd.start_minus) begin
            on_minus_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.probe_finish && (!on_minus_ff || probe_hit)) begin
         found_ff       <= probe_hit;
         slot_ff        <= addr_ff;
         hit_count_ff   <= rd_ff.count;
         hit_written_ff <= rd_ff.written;
         hit_hash_ff    <= probe_key;
      end
      if (dp_cmd.probe_finish && !on_minus_ff) begin
         pfree_ff <= probe_free;
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[addr_in];
   end

   // commit
   assign ab_eff     = !use_abund_ff ? ABUND_W'(1) :
                       (abund_ff == '0) ? ABUND_W'(1) : abund_ff;
   assign cnt_sum    = {1'b0, hit_count_ff} + (COUNT_W+1)'(ab_eff);
   assign cnt_sat    = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
   assign tot_sum    = {1'b0, total_ff} + (SUM_W+1)'(ab_eff);
   assign table_full = !found_ff && (!pfree_ff || (distinct_ff >= CNT_W'(FILL_LIMIT)));

   always_comb begin
      status_in    = STATUS_ABSENT;
      count_in     = '0;
      slot_in      = '0;
      distinct_in  = distinct_ff;
      max_count_in = max_count_ff;
      total_in     = total_ff;
      selected_in  = selected_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      if (len_ff < min_length_ff) begin
         status_in = STATUS_SHORT;
      end else if (len_ff > max_length_ff) begin
         status_in = STATUS_LONG;
      end else if (!opcode_ff) begin
         if (table_full) begin
            status_in = STATUS_FULL;
         end else begin
            slot_in = slot_ff;
            wr_en   = dp_cmd.commit;
            wr_addr = slot_ff;
            if (found_ff) begin
               status_in = STATUS_ADDED;
               count_in  = cnt_sat;
               wr_data   = '{hash: hit_hash_ff, count: cnt_sat, written: hit_written_ff};
            end else begin
               status_in   = STATUS_NEW;
               count_in    = COUNT_W'(ab_eff);
               distinct_in = distinct_ff + 1'b1;
               wr_data     = '{hash: plus_hash_ff, count: COUNT_W'(ab_eff), written: 1'b0};
            end
            total_in = tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
            if (count_in > max_count_ff) begin
               max_count_in = count_in;
            end
         end
      end else if (found_ff && !hit_written_ff) begin
         slot_in  = slot_ff;
         count_in = hit_count_ff;
         wr_en    = dp_cmd.commit;
         wr_addr  = slot_ff;
         wr_data  = '{hash: hit_hash_ff, count: hit_count_ff, written: 1'b1};
         if (hit_count_ff >= min_unique_ff && hit_count_ff <= max_unique_ff) begin
            status_in   = STATUS_WRITE;
            selected_in = selected_ff + 1'b1;
         end else begin
            status_in = STATUS_OUT_OF_BOUNDS;
         end
      end
      // clearing pass owns the write port
      if (dp_cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = addr_ff;
         wr_data = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff  <= '0;
         max_count_ff <= '0;
         total_ff     <= '0;
         selected_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.commit) begin
            distinct_ff  <= distinct_in;
            max_count_ff <= max_count_in;
            total_ff     <= total_in;
            selected_ff  <= selected_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_status        <= status_in;
         rsp_cluster_count <= count_in;
         rsp_slot_index    <= slot_in;
         rsp_cluster_total <= distinct_in;
         rsp_largest_count <= max_count_in;
         rsp_abundance_sum <= total_in;
         rsp_written_total <= selected_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign dp_status.clear_last   = (addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign dp_status.length_bad   = (len_ff < min_length_ff) || (len_ff > max_length_ff);
   assign dp_status.probe_hit    = probe_hit;
   assign dp_status.probe_done   = probe_hit || probe_free || probe_last;
   assign dp_status.on_minus     = on_minus_ff;
   assign dp_status.both_strands = both_strands_ff;
   assign dp_status.rsp_free     = !rsp_valid_ff || !rsp_stall;

endmodule

>>> hw/rtl/dereplication_hash_counter.sv
// Hash table counter for sequence dereplication: one result per item. After reset the
// table is swept clear, one slot a cycle, and no item is taken meanwhile (configuration
// writes are). An item then passes a length check, a linear probe (plus strand, then
// reverse complement when enabled and missed) reading one slot a cycle, and a commit;
// no new item is taken until its result is committed. The single-port table read sets
// the probe rate. The home slot is the low hash bits, so TABLE_ENTRIES must be a power
// of two; the block does not check it. New entries are refused at 95% table fill.
// depends on dhc_pkg, dhc_ctrl, dhc_datapath
module dereplication_hash_counter #(
   parameter int TABLE_ENTRIES = dhc_pkg::TABLE_ENTRIES_DEF,
   localparam int IDX_W = $clog2(TABLE_ENTRIES),
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dhc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dhc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [dhc_pkg::HASH_W-1:0]      req_plus_hash_high,
   input  logic [dhc_pkg::HASH_W-1:0]      req_plus_hash_low,
   input  logic [dhc_pkg::HASH_W-1:0]      req_minus_hash_high,
   input  logic [dhc_pkg::HASH_W-1:0]      req_minus_hash_low,
   input  logic [dhc_pkg::LEN_W-1:0]       req_seq_length,
   input  logic [dhc_pkg::ABUND_W-1:0]     req_abundance,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dhc_pkg::status_type             rsp_status,
   output logic [dhc_pkg::COUNT_W-1:0]     rsp_cluster_count,
   output logic [IDX_W-1:0]                rsp_slot_index,
   output logic [CNT_W-1:0]                rsp_cluster_total,
   output logic [dhc_pkg::COUNT_W-1:0]     rsp_largest_count,
   output logic [dhc_pkg::SUM_W-1:0]       rsp_abundance_sum,
   output logic [CNT_W-1:0]                rsp_written_total
);
   import dhc_pkg::*;

   localparam int FILL_LIMIT = (FILL_NUM * TABLE_ENTRIES) / FILL_DEN;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   dhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   dhc_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_opcode          (req_opcode),
      .req_plus_hash_high  (req_plus_hash_high),
      .req_plus_hash_low   (req_plus_hash_low),
      .req_minus_hash_high (req_minus_hash_high),
      .req_minus_hash_low  (req_minus_hash_low),
      .req_seq_length      (req_seq_length),
      .req_abundance       (req_abundance),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_cluster_count   (rsp_cluster_count),
      .rsp_slot_index      (rsp_slot_index),
      .rsp_cluster_total   (rsp_cluster_total),
      .rsp_largest_count   (rsp_largest_count),
      .rsp_abundance_sum   (rsp_abundance_sum),
      .rsp_written_total   (rsp_written_total),
      .dp_cmd              (dp_cmd),
      .dp_status           (dp_status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block took a new transaction while one is in flight");

   a_no_entry_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_SHORT || rsp_status == STATUS_LONG ||
                     rsp_status == STATUS_FULL || rsp_status == STATUS_ABSENT))
      |-> (rsp_cluster_count == '0 && rsp_slot_index == '0))
      else $error("entry fields not zero on a result without an entry");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cluster_total <= CNT_W'(FILL_LIMIT)))
      else $error("distinct entries beyond fill limit");

   a_new_entry_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_NEW) |-> (rsp_cluster_count != '0))
      else $error("new entry created with zero count");

endmodule

>>> sim/dhc_checker.sv
// result checker for the dereplication hash counter: watches the configuration, request
// and result channels, predicts each result from its own copy of the table and compares them
// depends on dhc_pkg
module dhc_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [63:0]          req_plus_hash_high,
   input  logic [63:0]          req_plus_hash_low,
   input  logic [63:0]          req_minus_hash_high,
   input  logic [63:0]          req_minus_hash_low,
   input  logic [31:0]          req_seq_length,
   input  logic [23:0]          req_abundance,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dhc_pkg::status_type  rsp_status,
   input  logic [31:0]          rsp_cluster_count,
   input  logic [11:0]          rsp_slot_index,
   input  logic [12:0]          rsp_cluster_total,
   input  logic [31:0]          rsp_largest_count,
   input  logic [39:0]          rsp_abundance_sum,
   input  logic [12:0]          rsp_written_total,
   output int                   failures,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dhc_pkg::*;

   localparam int SLOTS = 4096;

   typedef struct packed {
      status_type  status;
      logic [31:0] count;
      logic [11:0] slot;
      logic [12:0] total;
      logic [31:0] largest;
      logic [39:0] sum;
      logic [12:0] written;
   } tally_t;

   tally_t      tally_queue[$];
   logic [63:0] key_high[SLOTS];
   logic [63:0] key_low[SLOTS];
   logic [31:0] slot_count[SLOTS];
   logic        slot_written[SLOTS];
   logic [31:0] lo_len, hi_len, lo_size, hi_size;
   logic        dual_strand, add_abundance;
   logic [12:0] distinct;
   logic [31:0] peak;
   logic [39:0] abund_total;
   logic [12:0] selected;

   assign pending = tally_queue.size();

   function automatic logic find_slot(input logic [63:0] hi, input logic [63:0] lo,
                                      output int slot, output logic vacant);
      int s;
      s = int'(lo[11:0]);
      vacant = 0;
      slot = 0;
      for (int n = 0; n < SLOTS; n++) begin
         if (slot_count[s] == 0) begin
            slot = s;
            vacant = 1;
            return 0;
         end
         if (key_high[s] == hi && key_low[s] == lo) begin
            slot = s;
            return 1;
         end
         s = (s + 1) % SLOTS;
      end
      return 0;
   endfunction

   function automatic tally_t predict_tally();
      tally_t t;
      int pslot, mslot, slot;
      logic pfree, mfree, hit;
      logic [32:0] sum33;
      logic [40:0] sum41;
      logic [31:0] ab;
      t = '0;
      slot = 0;
      if (req_seq_length < lo_len) begin
         t.status = STATUS_SHORT;
      end else if (req_seq_length > hi_len) begin
         t.status = STATUS_LONG;
      end else begin
         hit = find_slot(req_plus_hash_high, req_plus_hash_low, pslot, pfree);
         slot = pslot;
         if (!hit && dual_strand) begin
            if (find_slot(req_minus_hash_high, req_minus_hash_low, mslot, mfree)) begin
               hit = 1;
               slot = mslot;
            end
         end
         if (req_opcode == 1'b0) begin
            ab = add_abundance ? ((req_abundance == 0) ? 32'd1 : 32'(req_abundance)) : 32'd1;
            if (!hit && (!pfree || 100 * (int'(distinct) + 1) > 95 * SLOTS)) begin
               t.status = STATUS_FULL;
               slot = 0;
            end else begin
               if (hit) begin
                  sum33 = {1'b0, slot_count[slot]} + ab;
                  slot_count[slot] = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                  t.status = STATUS_ADDED;
               end else begin
                  slot_count[slot] = ab;
                  key_high[slot] = req_plus_hash_high;
                  key_low[slot] = req_plus_hash_low;
                  slot_written[slot] = 0;
                  distinct++;
                  t.status = STATUS_NEW;
               end
               sum41 = {1'b0, abund_total} + ab;
               abund_total = sum41[40] ? 40'hFF_FFFF_FFFF : sum41[39:0];
               t.count = slot_count[slot];
               if (t.count > peak) peak = t.count;
            end
         end else begin
            if (!hit || slot_written[slot]) begin
               t.status = STATUS_ABSENT;
               slot = 0;
            end else begin
               t.count = slot_count[slot];
               if (t.count >= lo_size && t.count <= hi_size) begin
                  selected++;
                  t.status = STATUS_WRITE;
               end else begin
                  t.status = STATUS_OUT_OF_BOUNDS;
               end
               slot_written[slot] = 1;
            end
         end
      end
      t.slot = 12'(slot);
      t.total = distinct;
      t.largest = peak;
      t.sum = abund_total;
      t.written = selected;
      return t;
   endfunction

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      failures++;
      $display("%0t mismatch %s: expected %0h actual %0h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      tally_t want;
      if (reset) begin
         lo_len = 1; hi_len = '1; lo_size = 1; hi_size = '1;
         dual_strand = 0; add_abundance = 0;
         distinct = 0; peak = 0; abund_total = 0; selected = 0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_count[i] = 0;
            slot_written[i] = 0;
         end
         failures = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MIN_LENGTH:          lo_len = csr_data;
               CSR_MAX_LENGTH:          hi_len = csr_data;
               CSR_BOTH_STRANDS:        dual_strand = csr_data[0];
               CSR_USE_INPUT_ABUNDANCE: add_abundance = csr_data[0];
               CSR_MIN_UNIQUE_SIZE:     lo_size = csr_data;
               CSR_MAX_UNIQUE_SIZE:     hi_size = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) tally_queue.push_back(predict_tally());
         if (rsp_valid && !rsp_stall) begin
            if (tally_queue.size() == 0) begin
               failures++;
               $display("%0t unexpected transaction, status %0d", $realtime, rsp_status);
            end else begin
               want = tally_queue.pop_front();
               if (rsp_status != want.status) report("status", want.status, rsp_status);
               if (rsp_cluster_count != want.count)
                  report("cluster_count", want.count, rsp_cluster_count);
               if (rsp_slot_index != want.slot) report("slot_index", want.slot, rsp_slot_index);
               if (rsp_cluster_total != want.total)
                  report("cluster_total", want.total, rsp_cluster_total);
               if (rsp_largest_count != want.largest)
                  report("largest_count", want.largest, rsp_largest_count);
               if (rsp_abundance_sum != want.sum)
                  report("abundance_sum", want.sum, rsp_abundance_sum);
               if (rsp_written_total != want.written)
                  report("written_total", want.written, rsp_written_total);
            end
         end
      end
   end
endmodule

>>> sim/tb.sv
// testbench top for the dereplication hash counter: clock, reset, stimulus,
// configuration phases and verdict
// depends on dhc_pkg, dereplication_hash_counter and dhc_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dhc_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_opcode = 0;
   logic [63:0] req_plus_hash_high = '0, req_plus_hash_low = '0;
   logic [63:0] req_minus_hash_high = '0, req_minus_hash_low = '0;
   logic [31:0] req_seq_length = '0;
   logic [23:0] req_abundance = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1;
   status_type  rsp_status;
   logic [31:0] rsp_cluster_count, rsp_largest_count;
   logic [11:0] rsp_slot_index;
   logic [12:0] rsp_cluster_total, rsp_written_total;
   logic [39:0] rsp_abundance_sum;
   int          failures, pending;
   logic        calm = 0;
   int          hold_off = 0;

   // small key pool so that repeats, probe chains and both strands are hit
   logic [63:0] pool_high[64];
   logic [63:0] pool_low[64];

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   dereplication_hash_counter dut (.*);
   dhc_checker checker_i (.*);

   initial begin
      #60ms;
      $display("** dereplication_hash_counter: FAILED **");
      $finish;
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1;
      else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else rsp_stall <= !calm && ($urandom_range(99) < 15);
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic send(input logic op, input int a, input int b, input logic [31:0] len,
                       input logic [23:0] ab);
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_plus_hash_high <= pool_high[a];
      req_plus_hash_low <= pool_low[a];
      req_minus_hash_high <= pool_high[b];
      req_minus_hash_low <= pool_low[b];
      req_seq_length <= len;
      req_abundance <= ab;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid <= 0;
      @(negedge clock);
   endtask

   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic random_items(input int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 65)
            send(0, $urandom_range(63), $urandom_range(63), $urandom_range(300),
                 24'($urandom));
         else if (r < 90)
            send(1, $urandom_range(63), $urandom_range(63), $urandom_range(300),
                 24'($urandom));
         else begin
            pool_high[0] = {$urandom, $urandom};
            pool_low[0] = {$urandom, $urandom};
            send($urandom_range(1), 0, $urandom_range(63), $urandom, 24'($urandom));
         end
      end
   endtask

   initial begin
      for (int i = 0; i < 64; i++) begin
         pool_high[i] = {$urandom, $urandom};
         // several keys share a home slot to build probe chains and wrap-around
         pool_low[i] = (i < 8) ? {$urandom, 20'h0, 12'hFFE + 12'(i % 2)} : {$urandom, $urandom};
      end
      pool_high[1] = '1; pool_low[1] = '1;
      pool_high[2] = '0; pool_low[2] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      calm = 1;
      // directed: extremes and every status except STATUS_FULL
      send(0, 1, 2, 0, 24'hFFFFFF);
      send(0, 1, 2, 32'hFFFF_FFFF, 24'hFFFFFF);
      send(1, 1, 2, 0, 1);
      send(0, 1, 2, 5, 1);
      send(0, 2, 1, 5, 1);
      send(0, 3, 4, 5, 1);
      send(0, 4, 3, 5, 1);
      send(1, 1, 2, 5, 1);
      send(1, 1, 2, 5, 1);
      send(0, 1, 2, 5, 1);
      send(1, 9, 9, 5, 1);
      settle();
      write_reg(CSR_MIN_LENGTH, 10);
      write_reg(CSR_MAX_LENGTH, 20);
      write_reg(CSR_BOTH_STRANDS, 1);
      write_reg(CSR_USE_INPUT_ABUNDANCE, 1);
      write_reg(CSR_MIN_UNIQUE_SIZE, 2);
      write_reg(CSR_MAX_UNIQUE_SIZE, 100);
      send(0, 1, 2, 9, 1);
      send(0, 1, 2, 21, 1);
      send(0, 10, 11, 10, 0);
      send(0, 12, 10, 20, 24'hFFFFFF);
      send(0, 13, 10, 15, 50);
      send(1, 13, 10, 15, 1);
      send(1, 14, 14, 15, 1);
      send(0, 14, 14, 15, 1);
      send(1, 14, 14, 15, 1);
      settle();
      // long receiver hold-off while items keep coming
      hold_off = 400;
      random_items(40);
      calm = 0;
      settle();
      write_reg(CSR_MIN_LENGTH, 0);
      write_reg(CSR_MAX_LENGTH, 32'hFFFF_FFFF);
      write_reg(CSR_USE_INPUT_ABUNDANCE, 1);
      write_reg(CSR_MIN_UNIQUE_SIZE, 0);
      write_reg(CSR_MAX_UNIQUE_SIZE, 32'hFFFF_FFFF);
      random_items(300);
      settle();
      write_reg(CSR_BOTH_STRANDS, 0);
      write_reg(CSR_USE_INPUT_ABUNDANCE, 0);
      write_reg(CSR_MIN_LENGTH, 100);
      write_reg(CSR_MAX_LENGTH, 200);
      write_reg(CSR_MIN_UNIQUE_SIZE, 3);
      write_reg(CSR_MAX_UNIQUE_SIZE, 3);
      random_items(300);
      settle();
      write_reg(CSR_BOTH_STRANDS, 1);
      write_reg(CSR_USE_INPUT_ABUNDANCE, 1);
      write_reg(CSR_MIN_LENGTH, 32'hFFFF_FFFF);
      write_reg(CSR_MAX_LENGTH, 0);
      random_items(20);
      settle();
      write_reg(CSR_MIN_LENGTH, 1);
      write_reg(CSR_MAX_LENGTH, 32'hFFFF_FFFF);
      calm = 1;
      random_items(150);
      calm = 0;
      random_items(200);
      settle();
      if (failures == 0) begin
         $display("** dereplication_hash_counter: PASSED **");
      end else begin
         $display("** dereplication_hash_counter: FAILED **");
      end
      $finish;
   end
endmodule
